// ===== hw/rtl/tbwp_pkg.sv =====
package tbwp_pkg;

    localparam int VRAM_ADDR_W = 13;
    localparam int WORD_ADDR_W = VRAM_ADDR_W - 1;
    localparam int VRAM_WORDS  = 1 << WORD_ADDR_W;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 8;
    localparam int COLOUR_W    = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_X    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TOP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEFT = 3'd4;

    localparam int CTRL_BG_ON      = 0;
    localparam int CTRL_BG_MAP     = 3;
    localparam int CTRL_TILE_DATA  = 4;
    localparam int CTRL_WIN_ON     = 5;
    localparam int CTRL_WIN_MAP    = 6;

    localparam logic       MODE_WRITE    = 1'b0;
    localparam logic       MODE_PIXEL    = 1'b1;
    localparam logic [1:0] MAP_BASE_BITS = 2'b11;
    localparam logic [COORD_W-1:0] WINDOW_X_OFFSET = 8'd7;

endpackage

// ===== hw/rtl/tile_background_window_pixel_top.sv =====
// A pixel request passes the map word, tile row and colour registers before m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; a memory write gives no result.
// The map read and the tile row read each use a port of the video memory in their own stage.
// Reset (aresetn, synchronous, active low) clears the pipeline valid bits and the
// configuration registers; the video memory is not cleared and holds whatever it held.
module tile_background_window_pixel_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vram_address[12:0], write_data[20:13], pixel_x[28:21], pixel_line[36:29], zero above.
    input  logic [tbwp_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode[0].
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // colour_index[1:0], zero above.
    output logic [tbwp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // from_window[0].
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [tbwp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tbwp_pkg::BYTE_W-1:0]       cfg_wdata
);
    import tbwp_pkg::*;

    logic [BYTE_W-1:0] control_reg;
    logic [BYTE_W-1:0] scroll_y_reg;
    logic [BYTE_W-1:0] scroll_x_reg;
    logic [BYTE_W-1:0] window_top_reg;
    logic [BYTE_W-1:0] window_left_reg;

    logic [2*BYTE_W-1:0] vram_mem [VRAM_WORDS];

    logic [VRAM_ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0]      in_wdata;
    logic [COORD_W-1:0]     in_x;
    logic [COORD_W-1:0]     in_line;
    logic                   in_accept;
    logic                   in_write;
    logic                   in_pixel;

    logic                   win_hit;
    logic [COORD_W-1:0]     win_col;
    logic [COORD_W-1:0]     win_row;
    logic [COORD_W-1:0]     bg_col;
    logic [COORD_W-1:0]     bg_row;
    logic [COORD_W-1:0]     col_next;
    logic [COORD_W-1:0]     row_next;
    logic                   map_sel;
    logic                   layer_next;
    logic [VRAM_ADDR_W-1:0] map_addr;

    logic                   en1;
    logic                   en2;
    logic                   en3;

    logic                   v1_reg;
    logic [2:0]             col1_reg;
    logic [2:0]             row1_reg;
    logic                   byte_sel1_reg;
    logic                   win1_reg;
    logic                   layer1_reg;
    logic [2*BYTE_W-1:0]    map_word_reg;

    logic [BYTE_W-1:0]      tile_idx;
    logic                   signed_base;
    logic [WORD_ADDR_W-1:0] plane_addr;

    logic                   v2_reg;
    logic [2:0]             col2_reg;
    logic                   win2_reg;
    logic                   layer2_reg;
    logic [2*BYTE_W-1:0]    plane_word_reg;

    logic [2:0]             bit_sel;
    logic [COLOUR_W-1:0]    colour_next;

    logic                   v3_reg;
    logic [COLOUR_W-1:0]    colour_reg;
    logic                   win3_reg;

    assign in_addr   = s_tdata[12:0];
    assign in_wdata  = s_tdata[20:13];
    assign in_x      = s_tdata[28:21];
    assign in_line   = s_tdata[36:29];
    assign in_accept = s_tvalid && s_tready;
    assign in_write  = in_accept && (s_tuser[0] == MODE_WRITE);
    assign in_pixel  = in_accept && (s_tuser[0] == MODE_PIXEL);

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg     <= '0;
            scroll_y_reg    <= '0;
            scroll_x_reg    <= '0;
            window_top_reg  <= '0;
            window_left_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CONTROL:     control_reg     <= cfg_wdata;
                CFG_SCROLL_Y:    scroll_y_reg    <= cfg_wdata;
                CFG_SCROLL_X:    scroll_x_reg    <= cfg_wdata;
                CFG_WINDOW_TOP:  window_top_reg  <= cfg_wdata;
                CFG_WINDOW_LEFT: window_left_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The window test compares x + 7 against the left edge without wrapping.
    always_comb begin
        win_hit    = control_reg[CTRL_WIN_ON] && (in_line >= window_top_reg) &&
                     (({1'b0, in_x} + {1'b0, WINDOW_X_OFFSET}) >= {1'b0, window_left_reg});
        win_col    = in_x + WINDOW_X_OFFSET - window_left_reg;
        win_row    = in_line - window_top_reg;
        bg_col     = in_x + scroll_x_reg;
        bg_row     = in_line + scroll_y_reg;
        col_next   = win_hit ? win_col : bg_col;
        row_next   = win_hit ? win_row : bg_row;
        map_sel    = win_hit ? control_reg[CTRL_WIN_MAP] : control_reg[CTRL_BG_MAP];
        layer_next = win_hit || control_reg[CTRL_BG_ON];
        map_addr   = {MAP_BASE_BITS, map_sel, row_next[7:3], col_next[7:3]};
    end

    always_comb begin
        tile_idx    = byte_sel1_reg ? map_word_reg[15:8] : map_word_reg[7:0];
        signed_base = !control_reg[CTRL_TILE_DATA] && !tile_idx[7];
        plane_addr  = {signed_base, tile_idx, row1_reg};
    end

    always_comb begin
        bit_sel     = 3'd7 - col2_reg;
        colour_next = layer2_reg ?
                      {plane_word_reg[BYTE_W + bit_sel], plane_word_reg[bit_sel]} : '0;
    end

    always_ff @(posedge aclk) begin
        if (in_write) begin
            if (in_addr[0]) begin
                vram_mem[in_addr[VRAM_ADDR_W-1:1]][15:8] <= in_wdata;
            end else begin
                vram_mem[in_addr[VRAM_ADDR_W-1:1]][7:0] <= in_wdata;
            end
        end
        if (en1) begin
            map_word_reg <= vram_mem[map_addr[VRAM_ADDR_W-1:1]];
        end
        if (en2) begin
            plane_word_reg <= vram_mem[plane_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_pixel;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            col1_reg      <= col_next[2:0];
            row1_reg      <= row_next[2:0];
            byte_sel1_reg <= map_addr[0];
            win1_reg      <= win_hit;
            layer1_reg    <= layer_next;
        end
        if (en2) begin
            col2_reg   <= col1_reg;
            win2_reg   <= win1_reg;
            layer2_reg <= layer1_reg;
        end
        if (en3) begin
            colour_reg <= colour_next;
            win3_reg   <= win2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_DATA_W-COLOUR_W){1'b0}}, colour_reg};
    assign m_tuser  = win3_reg;

`ifndef SYNTHESIS
    a_pixel_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        in_pixel |=> v1_reg)
        else $error("Accepted pixel request did not enter the pipeline.");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_write |=> !v1_reg)
        else $error("Memory write entered the result pipeline.");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && en2) |=> v2_reg)
        else $error("Item lost between map fetch and tile row fetch.");

    a_window_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> control_reg[CTRL_WIN_ON])
        else $error("Window result while the window is disabled.");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
    import tbwp_pkg::*;

    localparam logic [VRAM_ADDR_W-1:0] MAP_LOW_BASE   = 13'h1800;
    localparam logic [VRAM_ADDR_W-1:0] MAP_HIGH_BASE  = 13'h1C00;
    localparam logic [VRAM_ADDR_W-1:0] SIGNED_TILE_BASE = 13'h1000;
    localparam int VRAM_BYTES   = 1 << VRAM_ADDR_W;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 30;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                from_window;
    } pixel_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;

    logic [BYTE_W-1:0]  vram_copy [VRAM_BYTES];
    bit                 vram_written [VRAM_BYTES];
    logic [BYTE_W-1:0]  lcd_control;
    logic [COORD_W-1:0] bg_scroll_y;
    logic [COORD_W-1:0] bg_scroll_x;
    logic [COORD_W-1:0] win_top;
    logic [COORD_W-1:0] win_left;

    pixel_result_t pending_pixels [$];
    bit idle_on = 1'b1;
    int ready_hold = 0;
    int errors = 0;

    tile_background_window_pixel_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic pick_layer(input logic [COORD_W-1:0] px,
                                        input logic [COORD_W-1:0] line,
                                        output logic [VRAM_ADDR_W-1:0] map_base,
                                        output logic [COORD_W-1:0] col,
                                        output logic [COORD_W-1:0] row,
                                        output logic from_win);
        logic [COORD_W:0] reach;
        reach = {1'b0, px} + {1'b0, WINDOW_X_OFFSET};
        map_base = '0;
        col = '0;
        row = '0;
        from_win = 1'b0;
        if (lcd_control[CTRL_WIN_ON] && line >= win_top && reach >= {1'b0, win_left}) begin
            map_base = lcd_control[CTRL_WIN_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
            col = reach[COORD_W-1:0] - win_left;
            row = line - win_top;
            from_win = 1'b1;
            return 1'b1;
        end
        if (lcd_control[CTRL_BG_ON]) begin
            map_base = lcd_control[CTRL_BG_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
            col = px + bg_scroll_x;
            row = line + bg_scroll_y;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [VRAM_ADDR_W-1:0] map_entry(input logic [VRAM_ADDR_W-1:0] map_base,
                                                         input logic [COORD_W-1:0] col,
                                                         input logic [COORD_W-1:0] row);
        return map_base + {3'b000, row[7:3], col[7:3]};
    endfunction

    function automatic logic [VRAM_ADDR_W-1:0] tile_row(input logic [BYTE_W-1:0] idx,
                                                        input logic [COORD_W-1:0] row);
        logic [VRAM_ADDR_W-1:0] tile_base;
        // Indices of 128 and above land below 0x9000 in signed mode, which is
        // the same byte offset as unsigned addressing gives.
        if (lcd_control[CTRL_TILE_DATA] || idx[7]) begin
            tile_base = {1'b0, idx, 4'b0000};
        end else begin
            tile_base = SIGNED_TILE_BASE + {1'b0, idx, 4'b0000};
        end
        return tile_base + {9'd0, row[2:0], 1'b0};
    endfunction

    function automatic logic [COLOUR_W-1:0] tile_colour(input logic [VRAM_ADDR_W-1:0] map_base,
                                                        input logic [COORD_W-1:0] col,
                                                        input logic [COORD_W-1:0] row);
        logic [VRAM_ADDR_W-1:0] row_addr;
        logic [BYTE_W-1:0] plane0;
        logic [BYTE_W-1:0] plane1;
        int b;
        row_addr = tile_row(vram_copy[map_entry(map_base, col, row)], row);
        plane0 = vram_copy[row_addr];
        plane1 = vram_copy[row_addr + 13'd1];
        b = 7 - col[2:0];
        return {plane1[b], plane0[b]};
    endfunction

    function automatic pixel_result_t predict_pixel(input logic [COORD_W-1:0] px,
                                                    input logic [COORD_W-1:0] line);
        pixel_result_t res;
        logic [VRAM_ADDR_W-1:0] map_base;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic from_win;
        logic covered;
        res = '0;
        covered = pick_layer(px, line, map_base, col, row, from_win);
        if (covered) begin
            res.colour = tile_colour(map_base, col, row);
            res.from_window = from_win;
        end
        return res;
    endfunction

    task automatic send_item(input logic mode, input logic [VRAM_ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] wdata, input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] line);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, line, px, wdata, addr};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        if (mode == MODE_WRITE) begin
            vram_copy[addr] = wdata;
            vram_written[addr] = 1'b1;
        end else begin
            pending_pixels.push_back(predict_pixel(px, line));
        end
    endtask

    task automatic send_write(input logic [VRAM_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] wdata);
        send_item(MODE_WRITE, addr, wdata, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Bytes that a pixel request would read are written first when they hold nothing yet.
    task automatic fill_reads(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] line);
        logic [VRAM_ADDR_W-1:0] map_base;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic from_win;
        logic covered;
        logic [VRAM_ADDR_W-1:0] entry;
        logic [VRAM_ADDR_W-1:0] row_addr;
        covered = pick_layer(px, line, map_base, col, row, from_win);
        if (covered) begin
            entry = map_entry(map_base, col, row);
            if (!vram_written[entry]) begin
                send_write(entry, BYTE_W'($urandom));
            end
            row_addr = tile_row(vram_copy[entry], row);
            if (!vram_written[row_addr]) begin
                send_write(row_addr, BYTE_W'($urandom));
            end
            if (!vram_written[row_addr + 13'd1]) begin
                send_write(row_addr + 13'd1, BYTE_W'($urandom));
            end
        end
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] line);
        fill_reads(px, line);
        send_item(MODE_PIXEL, VRAM_ADDR_W'($urandom), BYTE_W'($urandom), px, line);
    endtask

    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [7:0] ctrl, input logic [7:0] sy,
                                   input logic [7:0] sx, input logic [7:0] wt,
                                   input logic [7:0] wl);
        logic [CFG_ADDR_W-1:0] idx [5];
        logic [BYTE_W-1:0] val [5];
        idx = '{CFG_CONTROL, CFG_SCROLL_Y, CFG_SCROLL_X, CFG_WINDOW_TOP, CFG_WINDOW_LEFT};
        val = '{ctrl, sy, sx, wt, wl};
        drain_block();
        for (int i = 0; i < 5; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        lcd_control = ctrl;
        bg_scroll_y = sy;
        bg_scroll_x = sx;
        win_top     = wt;
        win_left    = wl;
    endtask

    task automatic test_directed_cases();
        write_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(MODE_PIXEL, 13'h1FFF, 8'hFF, 8'd0, 8'd0);
        send_item(MODE_PIXEL, 13'h0000, 8'h00, 8'd159, 8'd143);
        send_item(MODE_WRITE, 13'h0000, 8'h00, 8'hFF, 8'hFF);
        send_item(MODE_WRITE, 13'h1FFF, 8'hFF, 8'h00, 8'h00);
        send_write(MAP_LOW_BASE, 8'h00);
        send_write(MAP_LOW_BASE + 13'd1, 8'hFF);
        send_write(MAP_HIGH_BASE, 8'h7F);
        send_write(MAP_HIGH_BASE + 13'd1, 8'h80);

        write_registers(8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd8, 8'd0);

        write_registers(8'h19, 8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd8, 8'd0);
        send_pixel(8'd255, 8'd255);

        write_registers(8'h09, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'd1, 8'd1);
        send_pixel(8'd159, 8'd143);

        write_registers(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd159, 8'd143);

        write_registers(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);

        // Window on with the background off: uncovered pixels give no layer.
        write_registers(8'h20, 8'h00, 8'h00, 8'd100, 8'd50);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd43, 8'd100);
        send_pixel(8'd42, 8'd100);
        send_pixel(8'd43, 8'd99);
    endtask

    task automatic test_random_traffic();
        logic [VRAM_ADDR_W-1:0] addr;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p % 4 != 2);
            if (p == 0) begin
                write_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            end else if (p == 1) begin
                write_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            end else begin
                write_registers(8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom_range(0, 150)), 8'($urandom_range(0, 170)));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        addr = {MAP_BASE_BITS, 11'($urandom)};
                    end else begin
                        addr = VRAM_ADDR_W'($urandom);
                    end
                    send_write(addr, BYTE_W'($urandom));
                end else if ($urandom_range(0, 9) == 0) begin
                    send_pixel(COORD_W'($urandom), COORD_W'($urandom));
                end else begin
                    send_pixel(COORD_W'($urandom_range(0, 159)), COORD_W'($urandom_range(0, 143)));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    always @(negedge aclk) begin : drive_result_ready
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                ready_hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : check_results
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: colour_index %0d from_window %0d",
                       m_tdata[COLOUR_W-1:0], m_tuser[0]);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[COLOUR_W-1:0] !== want.colour) begin
                    $error("colour_index: expected %0d, got %0d", want.colour,
                           m_tdata[COLOUR_W-1:0]);
                    errors++;
                end
                if (m_tuser[0] !== want.from_window) begin
                    $error("from_window: expected %0d, got %0d", want.from_window, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        lcd_control = '0;
        bg_scroll_y = '0;
        bg_scroll_x = '0;
        win_top     = '0;
        win_left    = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_traffic();
        drain_block();
        repeat (6) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
